// ===== design/vbbc_pkg.sv =====
// ----------------------------------------------------------------------------
// vbbc_pkg: shared types and constants of the volume bounding box crop unit
// Field widths, reset defaults, result status codes and configuration register indexes.
// ----------------------------------------------------------------------------
package vbbc_pkg;

	localparam int VOXEL_W  = 8;
	localparam int COORD_W  = 13;
	localparam int SIZE_W   = 13;
	localparam int MARGIN_W = 8;
	localparam int CFG_IDX_W = 2;

	localparam int ROW_SIZE_RST    = 256;
	localparam int COLUMN_SIZE_RST = 256;
	localparam int SLICE_COUNT_RST = 256;
	localparam int MARGIN_RST      = 2;

	typedef enum logic [1:0] {
		STATUS_OK     = 2'd0,
		STATUS_BORDER = 2'd1,
		STATUS_EMPTY  = 2'd2
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ROW_SIZE     = 2'd0,
		CFG_COLUMN_SIZE  = 2'd1,
		CFG_SLICE_COUNT  = 2'd2,
		CFG_FRAME_MARGIN = 2'd3
	} cfg_idx_t;

endpackage

// ===== design/volume_bounding_box_crop_unit.sv =====
// ----------------------------------------------------------------------------
// volume_bounding_box_crop_unit: bounding box of the nonzero voxels of a volume
// Streams a byte volume in raster order and reports its framed bounding box.
// ----------------------------------------------------------------------------
// Usage:
// Voxels arrive on the input channel (in_valid, in_ready, voxel_value) in
// raster order, x fastest, then y, then z, with the dimensions held in the
// configuration registers. After the last voxel of a volume one result beat
// leaves on the output channel (out_valid, out_ready): the status, the framed
// origin and the box extents. No other voxel produces a beat.
// Throughput is one voxel per cycle while results are taken, as the position
// counters and the extent registers update for each voxel. The result of a
// volume is registered after its last voxel has passed the input stage.
// When the receiver stalls, the result is held in the output register and
// the input stage fills; in_ready then drops until the result is taken.
// Reset loads the default dimensions of 256 and a margin of 2, and starts a
// fresh volume. Configuration writes (cfg_valid, cfg_ready, cfg_index,
// cfg_data) are always accepted and belong between volumes; a size written
// before the first voxel of a volume also resets that dimension's minimum.
// ----------------------------------------------------------------------------
module volume_bounding_box_crop_unit #(
	parameter int MAX_DIM = 4096
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [vbbc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [vbbc_pkg::SIZE_W-1:0]          cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [vbbc_pkg::VOXEL_W-1:0]         voxel_value,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [1:0]                           status,
	output logic signed [vbbc_pkg::COORD_W-1:0]  origin_x,
	output logic signed [vbbc_pkg::COORD_W-1:0]  origin_y,
	output logic signed [vbbc_pkg::COORD_W-1:0]  origin_z,
	output logic [vbbc_pkg::COORD_W-1:0]         box_width,
	output logic [vbbc_pkg::COORD_W-1:0]         box_height,
	output logic [vbbc_pkg::COORD_W-1:0]         box_depth
);
	import vbbc_pkg::*;

	localparam int SZ_W  = $clog2(MAX_DIM + 1);
	localparam int POS_W = $clog2(MAX_DIM);
	localparam int ROW_EFF_RST = (ROW_SIZE_RST > MAX_DIM) ? MAX_DIM : ROW_SIZE_RST;
	localparam int COL_EFF_RST = (COLUMN_SIZE_RST > MAX_DIM) ? MAX_DIM : COLUMN_SIZE_RST;
	localparam int SLC_EFF_RST = (SLICE_COUNT_RST > MAX_DIM) ? MAX_DIM : SLICE_COUNT_RST;

	// A size of zero behaves as one, and anything above the limit as the limit.
	function automatic logic [SZ_W-1:0] eff_size(input logic [SIZE_W-1:0] r);
		if (r == '0) begin
			return SZ_W'(1);
		end else if (32'(r) > 32'(MAX_DIM)) begin
			return SZ_W'(MAX_DIM);
		end else begin
			return SZ_W'(r);
		end
	endfunction

	function automatic logic touches(input logic [SZ_W-1:0] lo, input logic [POS_W-1:0] hi,
		input logic [SZ_W-1:0] size);
		return (32'(lo) <= 32'd1) || (32'(hi) + 32'd2 >= 32'(size));
	endfunction

	// configuration
	logic [SIZE_W-1:0]   row_size_q, column_size_q, slice_count_q;
	logic [MARGIN_W-1:0] frame_margin_q;
	logic                cfg_wr;
	logic [SZ_W-1:0]     rs_eff, cs_eff, sc_eff, cfg_eff;

	// input stage
	logic               valid_s1;
	logic [VOXEL_W-1:0] voxel_s1;

	// volume state
	logic [POS_W-1:0] pos_x_q, pos_y_q, pos_z_q;
	logic [SZ_W-1:0]  low_x_q, low_y_q, low_z_q;
	logic [POS_W-1:0] high_x_q, high_y_q, high_z_q;
	logic             seen_q;

	// step logic
	logic             en, step, hit, last, fresh;
	logic             wrap_x, wrap_y, wrap_z;
	logic [POS_W-1:0] px_n, py_n, pz_n;
	logic [SZ_W-1:0]  lx_n, ly_n, lz_n;
	logic [POS_W-1:0] hx_n, hy_n, hz_n;
	logic             border;
	status_t          status_n;

	// result register
	logic                out_valid_q;
	status_t             status_q;
	logic [COORD_W-1:0]  origin_x_q, origin_y_q, origin_z_q;
	logic [COORD_W-1:0]  width_q, height_q, depth_q;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;
	assign rs_eff    = eff_size(row_size_q);
	assign cs_eff    = eff_size(column_size_q);
	assign sc_eff    = eff_size(slice_count_q);
	assign cfg_eff   = eff_size(cfg_data);

	assign en       = !out_valid_q || out_ready;
	assign step     = valid_s1 && en;
	assign in_ready = !valid_s1 || en;
	assign fresh    = (pos_x_q == '0) && (pos_y_q == '0) && (pos_z_q == '0) && !seen_q;

	always_comb begin
		hit  = voxel_s1 != '0;
		lx_n = (hit && 32'(pos_x_q) < 32'(low_x_q)) ? SZ_W'(pos_x_q) : low_x_q;
		ly_n = (hit && 32'(pos_y_q) < 32'(low_y_q)) ? SZ_W'(pos_y_q) : low_y_q;
		lz_n = (hit && 32'(pos_z_q) < 32'(low_z_q)) ? SZ_W'(pos_z_q) : low_z_q;
		hx_n = (hit && pos_x_q > high_x_q) ? pos_x_q : high_x_q;
		hy_n = (hit && pos_y_q > high_y_q) ? pos_y_q : high_y_q;
		hz_n = (hit && pos_z_q > high_z_q) ? pos_z_q : high_z_q;

		// A counter at or past its size wraps, even if the size shrank mid-volume.
		wrap_x = 32'(pos_x_q) + 32'd1 >= 32'(rs_eff);
		wrap_y = 32'(pos_y_q) + 32'd1 >= 32'(cs_eff);
		wrap_z = 32'(pos_z_q) + 32'd1 >= 32'(sc_eff);
		last   = wrap_x && wrap_y && wrap_z;

		px_n = wrap_x ? '0 : pos_x_q + 1'b1;
		py_n = wrap_x ? (wrap_y ? '0 : pos_y_q + 1'b1) : pos_y_q;
		pz_n = (wrap_x && wrap_y) ? (wrap_z ? '0 : pos_z_q + 1'b1) : pos_z_q;

		border = touches(lx_n, hx_n, rs_eff) || touches(ly_n, hy_n, cs_eff)
			|| touches(lz_n, hz_n, sc_eff);
		priority if (border) begin
			status_n = STATUS_BORDER;
		end else if (!(seen_q || hit)) begin
			status_n = STATUS_EMPTY;
		end else begin
			status_n = STATUS_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_size_q     <= SIZE_W'(ROW_SIZE_RST);
			column_size_q  <= SIZE_W'(COLUMN_SIZE_RST);
			slice_count_q  <= SIZE_W'(SLICE_COUNT_RST);
			frame_margin_q <= MARGIN_W'(MARGIN_RST);
		end else if (cfg_wr) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_ROW_SIZE:     row_size_q     <= cfg_data;
				CFG_COLUMN_SIZE:  column_size_q  <= cfg_data;
				CFG_SLICE_COUNT:  slice_count_q  <= cfg_data;
				CFG_FRAME_MARGIN: frame_margin_q <= cfg_data[MARGIN_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			voxel_s1 <= voxel_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q  <= '0;
			pos_y_q  <= '0;
			pos_z_q  <= '0;
			low_x_q  <= SZ_W'(ROW_EFF_RST);
			low_y_q  <= SZ_W'(COL_EFF_RST);
			low_z_q  <= SZ_W'(SLC_EFF_RST);
			high_x_q <= '0;
			high_y_q <= '0;
			high_z_q <= '0;
			seen_q   <= 1'b0;
		end else if (step) begin
			pos_x_q <= px_n;
			pos_y_q <= py_n;
			pos_z_q <= pz_n;
			if (last) begin
				low_x_q  <= rs_eff;
				low_y_q  <= cs_eff;
				low_z_q  <= sc_eff;
				high_x_q <= '0;
				high_y_q <= '0;
				high_z_q <= '0;
				seen_q   <= 1'b0;
			end else begin
				low_x_q  <= lx_n;
				low_y_q  <= ly_n;
				low_z_q  <= lz_n;
				high_x_q <= hx_n;
				high_y_q <= hy_n;
				high_z_q <= hz_n;
				seen_q   <= seen_q || hit;
			end
		end else if (cfg_wr && fresh) begin
			// Nothing seen yet in this volume, so the minimum follows the new size.
			unique case (cfg_idx_t'(cfg_index))
				CFG_ROW_SIZE:     low_x_q <= cfg_eff;
				CFG_COLUMN_SIZE:  low_y_q <= cfg_eff;
				CFG_SLICE_COUNT:  low_z_q <= cfg_eff;
				CFG_FRAME_MARGIN: ;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= step && last;
		end
	end

	always_ff @(posedge clk) begin
		if (step && last) begin
			status_q <= status_n;
			if (status_n == STATUS_OK) begin
				origin_x_q <= COORD_W'(32'(lx_n) - 32'(frame_margin_q));
				origin_y_q <= COORD_W'(32'(ly_n) - 32'(frame_margin_q));
				origin_z_q <= COORD_W'(32'(lz_n) - 32'(frame_margin_q));
				width_q    <= COORD_W'(32'(hx_n) - 32'(lx_n) + 32'd1);
				height_q   <= COORD_W'(32'(hy_n) - 32'(ly_n) + 32'd1);
				depth_q    <= COORD_W'(32'(hz_n) - 32'(lz_n) + 32'd1);
			end else begin
				origin_x_q <= '0;
				origin_y_q <= '0;
				origin_z_q <= '0;
				width_q    <= '0;
				height_q   <= '0;
				depth_q    <= '0;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign origin_x   = $signed(origin_x_q);
	assign origin_y   = $signed(origin_y_q);
	assign origin_z   = $signed(origin_z_q);
	assign box_width  = width_q;
	assign box_height = height_q;
	assign box_depth  = depth_q;

	// A finished volume leaves the counters and the object flag cleared.
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		step && last |=> pos_x_q == '0 && pos_y_q == '0 && pos_z_q == '0 && !seen_q)
		else $error("volume state not cleared after the last voxel");

	// A rejected volume reports no geometry.
	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != STATUS_OK |-> origin_x == '0 && origin_y == '0
			&& origin_z == '0 && box_width == '0 && box_height == '0 && box_depth == '0)
		else $error("non-ok result carries geometry");

	// An accepted volume has seen at least one object voxel, so no extent is empty.
	a_nonempty_box: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == STATUS_OK |-> box_width != '0 && box_height != '0
			&& box_depth != '0)
		else $error("ok result with an empty extent");

	// A voxel held in the input stage during a stall is not lost or replaced.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !en |=> valid_s1 && $stable(voxel_s1))
		else $error("stalled voxel beat lost");

endmodule

// ===== tb/volume_bounding_box_crop_checker.sv =====
// ----------------------------------------------------------------------------
// Bounding box crop checker
// Watches the configuration, voxel and result channels of the crop unit. It
// keeps its own copy of the registers and of the scan state, and works out
// the crop result of every volume as its last voxel is taken. Each result
// beat is compared field by field with the oldest predicted crop. Mismatches
// are counted and the count is handed to the testbench top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module volume_bounding_box_crop_checker #(
	parameter int MAX_DIM = 4096
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	input  logic                                 cfg_ready,
	input  logic [vbbc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [vbbc_pkg::SIZE_W-1:0]          cfg_data,
	input  logic                                 in_valid,
	input  logic                                 in_ready,
	input  logic [vbbc_pkg::VOXEL_W-1:0]         voxel_value,
	input  logic                                 out_valid,
	input  logic                                 out_ready,
	input  logic [1:0]                           status,
	input  logic signed [vbbc_pkg::COORD_W-1:0]  origin_x,
	input  logic signed [vbbc_pkg::COORD_W-1:0]  origin_y,
	input  logic signed [vbbc_pkg::COORD_W-1:0]  origin_z,
	input  logic [vbbc_pkg::COORD_W-1:0]         box_width,
	input  logic [vbbc_pkg::COORD_W-1:0]         box_height,
	input  logic [vbbc_pkg::COORD_W-1:0]         box_depth,
	output int                                   error_count,
	output int                                   crops_pending,
	output int                                   volumes_closed
);
	import vbbc_pkg::*;

	typedef struct packed {
		status_t            verdict;
		logic [COORD_W-1:0] org_x;
		logic [COORD_W-1:0] org_y;
		logic [COORD_W-1:0] org_z;
		logic [COORD_W-1:0] ext_w;
		logic [COORD_W-1:0] ext_h;
		logic [COORD_W-1:0] ext_d;
	} crop_t;

	crop_t crop_queue[$];

	logic [SIZE_W-1:0]   row_reg, col_reg, slice_reg;
	logic [MARGIN_W-1:0] margin_reg;
	logic [11:0]         pos_x, pos_y, pos_z;
	logic [11:0]         hi_x, hi_y, hi_z;
	logic [12:0]         lo_x, lo_y, lo_z;
	bit                  seen;

	// A size of zero behaves as one, anything above the largest dimension as the largest.
	function automatic logic [12:0] clamp_size(input logic [12:0] r);
		if (r == 0)
			return 13'd1;
		if (r > MAX_DIM)
			return 13'(MAX_DIM);
		return r;
	endfunction

	function automatic bit touches_border(input logic [12:0] lo, input logic [11:0] hi,
			input logic [12:0] size);
		return lo <= 1 || int'(hi) >= int'(size) - 2;
	endfunction

	task automatic open_volume();
		pos_x = '0;
		pos_y = '0;
		pos_z = '0;
		lo_x = clamp_size(row_reg);
		lo_y = clamp_size(col_reg);
		lo_z = clamp_size(slice_reg);
		hi_x = '0;
		hi_y = '0;
		hi_z = '0;
		seen = 1'b0;
	endtask

	task automatic apply_register(input cfg_idx_t idx, input logic [SIZE_W-1:0] data);
		bit fresh;
		// Only a size written before the first voxel of a volume reloads its minimum.
		fresh = pos_x == 0 && pos_y == 0 && pos_z == 0 && !seen;
		case (idx)
		CFG_ROW_SIZE: begin
			row_reg = data;
			if (fresh)
				lo_x = clamp_size(data);
		end
		CFG_COLUMN_SIZE: begin
			col_reg = data;
			if (fresh)
				lo_y = clamp_size(data);
		end
		CFG_SLICE_COUNT: begin
			slice_reg = data;
			if (fresh)
				lo_z = clamp_size(data);
		end
		CFG_FRAME_MARGIN: begin
			margin_reg = data[MARGIN_W-1:0];
		end
		default: begin
		end
		endcase
	endtask

	task automatic track_voxel(input logic [VOXEL_W-1:0] v);
		logic [12:0] rs, cs, ds;
		bit          closed;
		crop_t       c;
		rs = clamp_size(row_reg);
		cs = clamp_size(col_reg);
		ds = clamp_size(slice_reg);
		closed = 1'b0;
		if (v != 0) begin
			if (pos_x < lo_x)
				lo_x = 13'(pos_x);
			if (pos_x > hi_x)
				hi_x = pos_x;
			if (pos_y < lo_y)
				lo_y = 13'(pos_y);
			if (pos_y > hi_y)
				hi_y = pos_y;
			if (pos_z < lo_z)
				lo_z = 13'(pos_z);
			if (pos_z > hi_z)
				hi_z = pos_z;
			seen = 1'b1;
		end
		// A counter left beyond a shrunken size wraps as though it had reached the end.
		if (int'(pos_x) + 1 >= int'(rs)) begin
			pos_x = '0;
			if (int'(pos_y) + 1 >= int'(cs)) begin
				pos_y = '0;
				if (int'(pos_z) + 1 >= int'(ds)) begin
					pos_z = '0;
					closed = 1'b1;
				end else begin
					pos_z = pos_z + 1;
				end
			end else begin
				pos_y = pos_y + 1;
			end
		end else begin
			pos_x = pos_x + 1;
		end
		if (closed) begin
			c = '0;
			if (touches_border(lo_x, hi_x, rs) || touches_border(lo_y, hi_y, cs) ||
					touches_border(lo_z, hi_z, ds)) begin
				c.verdict = STATUS_BORDER;
			end else if (!seen) begin
				c.verdict = STATUS_EMPTY;
			end else begin
				c.verdict = STATUS_OK;
				c.org_x = lo_x - 13'(margin_reg);
				c.org_y = lo_y - 13'(margin_reg);
				c.org_z = lo_z - 13'(margin_reg);
				c.ext_w = 13'(hi_x) - lo_x + 13'd1;
				c.ext_h = 13'(hi_y) - lo_y + 13'd1;
				c.ext_d = 13'(hi_z) - lo_z + 13'd1;
			end
			crop_queue.push_back(c);
			volumes_closed++;
			open_volume();
		end
	endtask

	task automatic report_mismatch(input string field, input int want, input int got);
		if (error_count < 100)
			$display("%0t: %s: expected %0d, got %0d", $time, field, want, got);
		error_count++;
	endtask

	task automatic check_crop();
		crop_t want;
		if (crop_queue.size() == 0) begin
			report_mismatch("result beat with no crop expected, status", 0, int'(status));
			return;
		end
		want = crop_queue.pop_front();
		if (status !== want.verdict)
			report_mismatch("status", int'(want.verdict), int'(status));
		if (origin_x !== want.org_x)
			report_mismatch("origin_x", $signed(want.org_x), origin_x);
		if (origin_y !== want.org_y)
			report_mismatch("origin_y", $signed(want.org_y), origin_y);
		if (origin_z !== want.org_z)
			report_mismatch("origin_z", $signed(want.org_z), origin_z);
		if (box_width !== want.ext_w)
			report_mismatch("box_width", want.ext_w, box_width);
		if (box_height !== want.ext_h)
			report_mismatch("box_height", want.ext_h, box_height);
		if (box_depth !== want.ext_d)
			report_mismatch("box_depth", want.ext_d, box_depth);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_reg = SIZE_W'(ROW_SIZE_RST);
			col_reg = SIZE_W'(COLUMN_SIZE_RST);
			slice_reg = SIZE_W'(SLICE_COUNT_RST);
			margin_reg = MARGIN_W'(MARGIN_RST);
			open_volume();
			crop_queue.delete();
			error_count = 0;
			crops_pending = 0;
			volumes_closed = 0;
		end else begin
			// A result beat can never come from a voxel taken at the same edge.
			if (out_valid && out_ready)
				check_crop();
			if (cfg_valid && cfg_ready)
				apply_register(cfg_idx_t'(cfg_index), cfg_data);
			if (in_valid && in_ready)
				track_voxel(voxel_value);
			crops_pending = crop_queue.size();
		end
	end

endmodule

// ===== tb/volume_bounding_box_crop_unit_tb.sv =====
// ----------------------------------------------------------------------------
// Bounding box crop unit testbench
// Streams byte volumes of many shapes through the crop unit: a few directed
// cases for degenerate sizes and mid-volume register changes, a long receiver
// hold-off, then random volumes with objects inside, at the border, empty and
// noisy, and finally a few volumes with sizes at or beyond the largest, each cut
// short by a size write. Both sides idle and stall at random in several
// phases. The checker predicts every crop result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module volume_bounding_box_crop_unit_tb;
	import vbbc_pkg::*;

	localparam int MAX_DIM        = 4096;
	localparam int IDLE_LIMIT     = 3000;
	localparam int SETTLE_CYCLES  = 8;
	localparam int HOLD_CYCLES    = 200;
	localparam int RANDOM_VOXELS  = 1200;

	typedef enum int {
		FILL_INTERIOR,
		FILL_EMPTY,
		FILL_SCATTER,
		FILL_NOISE
	} fill_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          cfg_valid = 1'b0;
	logic                          cfg_ready;
	logic [CFG_IDX_W-1:0]          cfg_index = '0;
	logic [SIZE_W-1:0]             cfg_data = '0;
	logic                          in_valid = 1'b0;
	logic                          in_ready;
	logic [VOXEL_W-1:0]            voxel_value = '0;
	logic                          out_valid;
	logic                          out_ready = 1'b0;
	logic [1:0]                    status;
	logic signed [COORD_W-1:0]     origin_x, origin_y, origin_z;
	logic [COORD_W-1:0]            box_width, box_height, box_depth;

	int error_count;
	int crops_pending;
	int volumes_closed;

	int sender_idle_pct = 0;
	int stall_pct = 0;
	bit hold_request = 1'b0;
	int hold_count = 0;
	int idle_cycles = 0;
	int voxels_sent = 0;

	// Register values as last written, used only to shape the voxel content.
	logic [SIZE_W-1:0] cur_row = SIZE_W'(ROW_SIZE_RST);
	logic [SIZE_W-1:0] cur_col = SIZE_W'(COLUMN_SIZE_RST);
	logic [SIZE_W-1:0] cur_slice = SIZE_W'(SLICE_COUNT_RST);

	int                group, r, nvol, closed_mark, dens;
	logic [SIZE_W-1:0] rs, cs, sc, md;
	fill_t             kind;
	cfg_idx_t          idx;

	volume_bounding_box_crop_unit #(
		.MAX_DIM(MAX_DIM)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.voxel_value(voxel_value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.origin_x(origin_x),
		.origin_y(origin_y),
		.origin_z(origin_z),
		.box_width(box_width),
		.box_height(box_height),
		.box_depth(box_depth)
	);

	volume_bounding_box_crop_checker #(
		.MAX_DIM(MAX_DIM)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.voxel_value(voxel_value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.origin_x(origin_x),
		.origin_y(origin_y),
		.origin_z(origin_z),
		.box_width(box_width),
		.box_height(box_height),
		.box_depth(box_depth),
		.error_count(error_count),
		.crops_pending(crops_pending),
		.volumes_closed(volumes_closed)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// The receiver holds off once for a long stretch when asked, otherwise stalls at random.
	always @(negedge clk) begin
		if (hold_request && hold_count < HOLD_CYCLES) begin
			out_ready <= 1'b0;
			hold_count <= hold_count + 1;
		end else begin
			out_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		if ((cfg_valid && cfg_ready) || (in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("[volume_bounding_box_crop_unit] ERROR");
			$finish;
		end
	end

	function automatic int span(input logic [SIZE_W-1:0] size);
		if (size == 0)
			return 1;
		if (size > MAX_DIM)
			return MAX_DIM;
		return int'(size);
	endfunction

	function automatic logic [VOXEL_W-1:0] pick_voxel(input fill_t fill, input int x, y, z,
			input int ex, ey, ez, input int density);
		bit inner;
		inner = x >= 2 && x <= ex - 3 && y >= 2 && y <= ey - 3 && z >= 2 && z <= ez - 3;
		case (fill)
		FILL_INTERIOR:
			return (inner && $urandom_range(99) < density) ? 8'($urandom_range(255, 1)) : 8'h00;
		FILL_SCATTER:
			return ($urandom_range(99) < density) ? 8'($urandom_range(255, 1)) : 8'h00;
		FILL_NOISE:
			return 8'($urandom_range(255));
		default:
			return 8'h00;
		endcase
	endfunction

	// Entered and left at a falling edge; valid stays high between back-to-back beats.
	task automatic push_voxel(input logic [VOXEL_W-1:0] v);
		if ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			do
				@(negedge clk);
			while ($urandom_range(99) < sender_idle_pct);
		end
		in_valid <= 1'b1;
		voxel_value <= v;
		do
			@(posedge clk);
		while (!in_ready);
		@(negedge clk);
		voxels_sent++;
	endtask

	task automatic write_reg(input cfg_idx_t reg_idx, input logic [SIZE_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= reg_idx;
		cfg_data <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		case (reg_idx)
		CFG_ROW_SIZE:    cur_row = data;
		CFG_COLUMN_SIZE: cur_col = data;
		CFG_SLICE_COUNT: cur_slice = data;
		default: begin
		end
		endcase
	endtask

	// Waits for every predicted crop, then for the pipeline to drain any trailing voxels.
	task automatic settle();
		in_valid <= 1'b0;
		while (crops_pending != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic configure(input logic [SIZE_W-1:0] row, col, slices, margin);
		settle();
		write_reg(CFG_ROW_SIZE, row);
		write_reg(CFG_COLUMN_SIZE, col);
		write_reg(CFG_SLICE_COUNT, slices);
		write_reg(CFG_FRAME_MARGIN, margin);
		cfg_valid <= 1'b0;
	endtask

	// Sends a run of voxels, then shrinks one size mid-volume and runs the volume out.
	task automatic cut_volume(input int count, input cfg_idx_t reg_idx,
			input logic [SIZE_W-1:0] size);
		int mark;
		repeat (count) push_voxel(8'($urandom_range(255)));
		settle();
		write_reg(reg_idx, size);
		cfg_valid <= 1'b0;
		mark = volumes_closed;
		while (volumes_closed == mark)
			push_voxel(8'($urandom_range(255)));
	endtask

	task automatic send_volume(input fill_t fill, input int density);
		int ex, ey, ez, x, y, z;
		ex = span(cur_row);
		ey = span(cur_col);
		ez = span(cur_slice);
		for (z = 0; z < ez; z++)
			for (y = 0; y < ey; y++)
				for (x = 0; x < ex; x++)
					push_voxel(pick_voxel(fill, x, y, z, ex, ey, ez, density));
	endtask

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Zero sizes act as one: every voxel is a whole volume lying on the border.
		configure(13'd0, 13'd0, 13'd0, 13'd0);
		push_voxel(8'h00);
		push_voxel(8'hFF);
		push_voxel(8'h01);
		push_voxel(8'h80);
		push_voxel(8'h55);
		push_voxel(8'hAA);

		// Upper data bits of a margin write are dropped.
		configure(13'd3, 13'd1, 13'd1, 13'h1F05);
		push_voxel(8'h00);
		push_voxel(8'h07);
		push_voxel(8'h00);

		// Row size shrinks below the current x position halfway through the first row of a volume.
		configure(13'd4, 13'd2, 13'd1, 13'd0);
		push_voxel(8'h7F);
		push_voxel(8'h00);
		settle();
		write_reg(CFG_ROW_SIZE, 13'd1);
		write_reg(CFG_FRAME_MARGIN, 13'd255);
		cfg_valid <= 1'b0;
		push_voxel(8'h10);
		push_voxel(8'h00);

		// Tiny volumes at full rate while the receiver holds off, so the input backs up.
		configure(13'd2, 13'd1, 13'd1, 13'd0);
		hold_request = 1'b1;
		repeat (80) push_voxel(8'($urandom_range(255)));

		voxels_sent = 0;
		group = 0;
		while (voxels_sent < RANDOM_VOXELS) begin
			case (group % 4)
			0: begin
				sender_idle_pct = 0;
				stall_pct = 0;
			end
			1: begin
				sender_idle_pct = 82;
				stall_pct = 0;
			end
			2: begin
				sender_idle_pct = 0;
				stall_pct = 82;
			end
			default: begin
				sender_idle_pct = 35;
				stall_pct = 35;
			end
			endcase
			if ($urandom_range(99) < 45) begin
				rs = 13'($urandom_range(7, 5));
				cs = 13'($urandom_range(7, 5));
				sc = 13'($urandom_range(7, 5));
			end else begin
				rs = 13'($urandom_range(4));
				cs = 13'($urandom_range(4));
				sc = 13'($urandom_range(4));
			end
			r = $urandom_range(99);
			md = {5'($urandom_range(31)),
				(r < 15) ? 8'd0 : (r < 30) ? 8'd255 : 8'($urandom_range(3))};
			configure(rs, cs, sc, md);
			nvol = $urandom_range(3, 1);
			repeat (nvol) begin
				r = $urandom_range(99);
				kind = (r < 50) ? FILL_INTERIOR : (r < 65) ? FILL_EMPTY :
					(r < 85) ? FILL_SCATTER : FILL_NOISE;
				r = $urandom_range(99);
				dens = (r < 33) ? 3 : (r < 66) ? 25 : 100;
				send_volume(kind, dens);
			end
			// Now and then a register is written partway through a volume, which is then run out.
			if ($urandom_range(99) < 15) begin
				repeat ($urandom_range(6, 1)) push_voxel(8'($urandom_range(255)));
				settle();
				idx = cfg_idx_t'($urandom_range(3));
				write_reg(idx, (idx == CFG_FRAME_MARGIN) ? 13'($urandom) : 13'($urandom_range(7)));
				cfg_valid <= 1'b0;
				closed_mark = volumes_closed;
				while (volumes_closed == closed_mark)
					push_voxel(8'($urandom_range(255)));
			end
			group++;
		end

		// Sizes beyond the maximum are clamped, a size at it is not; each volume is ended early by a smaller size.
		sender_idle_pct = 0;
		stall_pct = 35;
		configure(13'h1FFF, 13'd1, 13'd1, 13'd255);
		cut_volume(60, CFG_ROW_SIZE, 13'd64);
		configure(13'd2, 13'h1FFF, 13'd1, 13'd9);
		cut_volume(60, CFG_COLUMN_SIZE, 13'd40);
		configure(13'd1, 13'd1, 13'd4096, 13'd0);
		cut_volume(50, CFG_SLICE_COUNT, 13'd60);

		settle();
		if (error_count == 0 && crops_pending == 0)
			$display("[volume_bounding_box_crop_unit] OK");
		else
			$display("[volume_bounding_box_crop_unit] ERROR");
		$finish;
	end

endmodule

// ===== volume_bounding_box_crop_unit.f =====
design/vbbc_pkg.sv
design/volume_bounding_box_crop_unit.sv
tb/volume_bounding_box_crop_checker.sv
tb/volume_bounding_box_crop_unit_tb.sv
